>>> hdl/lmls_pkg.sv
// Shared types, constants and the STAT flag function for the LCD mode/line sequencer.
`default_nettype none
package lmls_pkg;

    localparam int VISIBLE_LINES = 144;
    localparam int FINAL_LINE    = 153;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS);

    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_SEARCH   = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_LCDC = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;
    localparam logic [1:0] KIND_LYC  = 2'd3;

    localparam logic [7:0] SLOT_SEARCH   = 8'd40;
    localparam logic [7:0] SLOT_TRANSFER = 8'd86;
    localparam logic [7:0] SLOT_HBLANK   = 8'd102;
    localparam logic [7:0] SLOT_LINE     = 8'd228;
    localparam logic [7:0] SLOT_SPLIT_A  = 8'd28;
    localparam logic [7:0] SLOT_SPLIT_B  = 8'd200;

    localparam logic [7:0] LCDC_RESET = 8'h80;

    typedef enum logic [2:0] {
        OP_IDLE   = 3'd0,
        OP_RUN_ON = 3'd1,
        OP_RUN_OFF = 3'd2,
        OP_LCDC   = 3'd3,
        OP_STAT   = 3'd4,
        OP_LYC    = 3'd5
    } op_t;

    typedef struct packed {
        logic [7:0] line_count;
        logic [1:0] mode;
        logic       coincidence;
        logic [3:0] stat_en;
        logic [7:0] lcdc;
        logic [7:0] compare;
        logic       vblank;
        logic       stat_level;
    } lcd_state_t;

    typedef struct packed {
        logic stat_rise;
        logic vblank_rise;
        logic frame_begin;
        logic line_render;
        logic hdma_step;
    } lcd_flags_t;

    function automatic logic stat_flag(input lcd_state_t s);
        logic f;
        f = 1'b0;
        if (s.coincidence && s.stat_en[3]) f = 1'b1;
        if (s.mode == MODE_HBLANK && s.stat_en[0]) f = 1'b1;
        if (s.mode == MODE_VBLANK && s.stat_en[1]) f = 1'b1;
        if (s.mode == MODE_SEARCH && s.stat_en[2]) f = 1'b1;
        if (!s.lcdc[7]) f = 1'b0;
        return f;
    endfunction

endpackage
`default_nettype wire

>>> hdl/lmls_step.sv
// One mode-machine step or register write applied to the LCD timing state.
`default_nettype none
module lmls_step (
    input  wire lmls_pkg::op_t        op,
    input  wire lmls_pkg::lcd_state_t st_in,
    input  wire logic [7:0]           value,
    input  wire logic                 hdma,
    input  wire logic                 color_mode,
    output lmls_pkg::lcd_state_t      st_out,
    output lmls_pkg::lcd_flags_t      flags,
    output logic [7:0]                cd_inc,
    output logic                      cd_set
);

    function automatic lmls_pkg::lcd_state_t recompute(input lmls_pkg::lcd_state_t s);
        lmls_pkg::lcd_state_t r;
        r = s;
        r.coincidence = (r.line_count == r.compare);
        r.stat_level  = lmls_pkg::stat_flag(r);
        return r;
    endfunction

    lmls_pkg::lcd_state_t s;
    lmls_pkg::lcd_flags_t fl;
    logic                 prev;
    logic                 entered;

    always_comb begin
        s       = st_in;
        fl      = '0;
        cd_inc  = '0;
        cd_set  = 1'b0;
        prev    = 1'b0;
        entered = 1'b0;
        case (op)
            lmls_pkg::OP_RUN_ON: begin
                case (s.mode)
                    lmls_pkg::MODE_HBLANK: begin
                        s.line_count = s.line_count + 8'd1;
                        s.mode = (s.line_count < 8'(lmls_pkg::VISIBLE_LINES)) ?
                                 lmls_pkg::MODE_SEARCH : lmls_pkg::MODE_VBLANK;
                        entered = 1'b1;
                    end
                    lmls_pkg::MODE_SEARCH: begin
                        s.mode = lmls_pkg::MODE_TRANSFER;
                        entered = 1'b1;
                    end
                    lmls_pkg::MODE_TRANSFER: begin
                        s.mode = lmls_pkg::MODE_HBLANK;
                        entered = 1'b1;
                    end
                    default: begin
                        if (s.line_count == 8'd0) begin
                            s.mode = lmls_pkg::MODE_SEARCH;
                            entered = 1'b1;
                        end
                    end
                endcase
                if (entered) begin
                    if (s.mode != lmls_pkg::MODE_VBLANK) s.vblank = 1'b0;
                    prev = s.stat_level;
                    s = recompute(s);
                    if (s.stat_level && !prev) fl.stat_rise = 1'b1;
                end
                case (s.mode)
                    lmls_pkg::MODE_SEARCH: begin
                        if (s.line_count == 8'd0) fl.frame_begin = 1'b1;
                        cd_inc = lmls_pkg::SLOT_SEARCH;
                    end
                    lmls_pkg::MODE_TRANSFER: begin
                        fl.line_render = 1'b1;
                        cd_inc = lmls_pkg::SLOT_TRANSFER;
                    end
                    lmls_pkg::MODE_HBLANK: begin
                        fl.hdma_step = hdma;
                        cd_inc = lmls_pkg::SLOT_HBLANK;
                    end
                    default: begin
                        if (!s.vblank) begin
                            cd_inc = lmls_pkg::SLOT_LINE;
                            s.vblank = 1'b1;
                            fl.vblank_rise = 1'b1;
                        end else begin
                            s.line_count = s.line_count + 8'd1;
                            if (s.line_count < 8'(lmls_pkg::FINAL_LINE)) begin
                                cd_inc = lmls_pkg::SLOT_LINE;
                            end else if (s.line_count == 8'(lmls_pkg::FINAL_LINE)) begin
                                cd_inc = lmls_pkg::SLOT_SPLIT_A;
                            end else begin
                                s.line_count = 8'd0;
                                cd_inc = lmls_pkg::SLOT_SPLIT_B;
                            end
                            prev = s.stat_level;
                            s = recompute(s);
                            if (s.stat_level && !prev) fl.stat_rise = 1'b1;
                        end
                    end
                endcase
            end
            lmls_pkg::OP_RUN_OFF: begin
                case (s.mode)
                    lmls_pkg::MODE_SEARCH: begin
                        s.mode = lmls_pkg::MODE_TRANSFER;
                        cd_inc = lmls_pkg::SLOT_TRANSFER;
                    end
                    lmls_pkg::MODE_TRANSFER: begin
                        s.mode = lmls_pkg::MODE_HBLANK;
                        cd_inc = lmls_pkg::SLOT_HBLANK;
                    end
                    default: begin
                        s.mode = lmls_pkg::MODE_SEARCH;
                        cd_inc = lmls_pkg::SLOT_SEARCH;
                    end
                endcase
                s.vblank = 1'b0;
                prev = s.stat_level;
                s = recompute(s);
                if (s.stat_level && !prev) fl.stat_rise = 1'b1;
                // hblank pass: advance the line after the STAT update
                if (st_in.mode == lmls_pkg::MODE_HBLANK) s.line_count = s.line_count + 8'd1;
            end
            lmls_pkg::OP_LCDC: begin
                s.lcdc = value;
                if (st_in.lcdc[7] != value[7]) begin
                    s.line_count = 8'd0;
                    s.mode = lmls_pkg::MODE_SEARCH;
                    s.vblank = 1'b0;
                    prev = s.stat_level;
                    s = recompute(s);
                    if (s.stat_level && !prev) fl.stat_rise = 1'b1;
                    cd_set = 1'b1;
                    fl.frame_begin = 1'b1;
                end
            end
            lmls_pkg::OP_STAT: begin
                s.stat_en = value[6:3];
                if (!color_mode && !s.mode[1]) begin
                    if (!s.stat_level) fl.stat_rise = 1'b1;
                    s.stat_level = 1'b1;
                end
                prev = s.stat_level;
                s = recompute(s);
                if (s.stat_level && !prev) fl.stat_rise = 1'b1;
            end
            lmls_pkg::OP_LYC: begin
                s.compare = value;
                prev = s.stat_level;
                s = recompute(s);
                if (s.stat_level && !prev) fl.stat_rise = 1'b1;
            end
            default: begin
            end
        endcase
        st_out = s;
        flags  = fl;
    end

endmodule
`default_nettype wire

>>> hdl/lcd_mode_line_sequencer.sv
// Top level of the LCD mode/line sequencer: sequencer, shared countdown adder, output register.
//
//   channel  ports                       direction  handshake
//   s_       kind value cycles hdma      in         s_valid / s_ready
//   m_       line mode stat ... last     out        m_valid / m_ready
//   cfg_     cfg_wdata (color mode)      in         cfg_we, no wait
//
// A register write is accepted, then gives one result beat.
// A tick with k result beats runs: accept, a pass on the shared adder (ST_SUB) to
// subtract the elapsed cycles, then one beat per mode step, each step reusing the adder.
// s_ready is high only while no item is in work.
// A stalled m_ready holds the result register and pauses the step sequencer.
// aresetn is synchronous: LCDC resets to 0x80, other LCD state to zero; data regs not reset.
`default_nettype none
module lcd_mode_line_sequencer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_kind,
    input  wire logic [7:0] s_value,
    input  wire logic [7:0] s_cycles,
    input  wire logic       s_hdma_active,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_line,
    output logic [1:0]      m_mode,
    output logic [6:0]      m_stat_byte,
    output logic            m_stat_line,
    output logic            m_vblank_line,
    output logic            m_stat_irq_rise,
    output logic            m_vblank_irq_rise,
    output logic            m_frame_begin,
    output logic            m_line_render,
    output logic            m_hdma_step,
    output logic            m_last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUB  = 3'b010,
        ST_STEP = 3'b100
    } seq_state_t;

    seq_state_t                state_reg, state_next;
    lmls_pkg::lcd_state_t      lcd_reg;
    lmls_pkg::lcd_state_t      lcd_next;
    lmls_pkg::lcd_flags_t      flags;
    logic signed [15:0]        cd_reg;
    logic [lmls_pkg::CNT_W-1:0] n_reg;
    logic                      color_reg;
    logic [1:0]                kind_reg;
    logic [7:0]                value_reg;
    logic [7:0]                cycles_reg;
    logic                      hdma_reg;

    lmls_pkg::op_t             op;
    logic [7:0]                cd_inc;
    logic                      cd_set;
    logic signed [16:0]        add_b;
    logic signed [16:0]        sum;
    logic signed [15:0]        cd_sat;
    logic                      cd_due;
    logic                      out_free;
    logic                      emit;
    logic                      last_c;
    logic                      m_valid_reg;

    lmls_step u_step (
        .op         (op),
        .st_in      (lcd_reg),
        .value      (value_reg),
        .hdma       (hdma_reg),
        .color_mode (color_reg),
        .st_out     (lcd_next),
        .flags      (flags),
        .cd_inc     (cd_inc),
        .cd_set     (cd_set)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign cd_due   = cd_reg[15] || (cd_reg == 16'sd0);

    always_comb begin
        op     = lmls_pkg::OP_IDLE;
        last_c = 1'b1;
        case (kind_reg)
            lmls_pkg::KIND_LCDC: op = lmls_pkg::OP_LCDC;
            lmls_pkg::KIND_STAT: op = lmls_pkg::OP_STAT;
            lmls_pkg::KIND_LYC:  op = lmls_pkg::OP_LYC;
            default: begin
                if (lcd_reg.lcdc[7]) begin
                    if (cd_due) op = lmls_pkg::OP_RUN_ON;
                end else if (cd_due) begin
                    op = lmls_pkg::OP_RUN_OFF;
                end
            end
        endcase
        if (state_reg == ST_SUB) begin
            add_b = -$signed({9'd0, cycles_reg});
        end else begin
            add_b = $signed({9'd0, cd_inc});
        end
        sum = $signed({cd_reg[15], cd_reg}) + add_b;
        if (sum[16] && !sum[15]) begin
            cd_sat = 16'sh8000;
        end else begin
            cd_sat = sum[15:0];
        end
        if (op == lmls_pkg::OP_RUN_ON) begin
            last_c = (!cd_sat[15] && cd_sat != 16'sd0) ||
                     (n_reg == lmls_pkg::CNT_W'(lmls_pkg::MAX_RESULTS - 1));
        end
    end

    assign emit = (state_reg == ST_STEP) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = (s_kind == lmls_pkg::KIND_TICK) ? ST_SUB : ST_STEP;
            end
            ST_SUB:  state_next = ST_STEP;
            ST_STEP: begin
                if (emit && last_c) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lcd_reg     <= '{line_count: 8'd0, mode: lmls_pkg::MODE_HBLANK, coincidence: 1'b0,
                             stat_en: 4'd0, lcdc: lmls_pkg::LCDC_RESET, compare: 8'd0,
                             vblank: 1'b0, stat_level: 1'b0};
            cd_reg      <= '0;
            n_reg       <= '0;
            color_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) color_reg <= cfg_wdata;
            if (state_reg == ST_SUB) begin
                cd_reg <= cd_sat;
                n_reg  <= '0;
            end
            if (emit) begin
                lcd_reg <= lcd_next;
                n_reg   <= n_reg + 1'b1;
                if (cd_set) begin
                    cd_reg <= 16'(lmls_pkg::SLOT_SEARCH);
                end else if (op == lmls_pkg::OP_RUN_ON || op == lmls_pkg::OP_RUN_OFF) begin
                    cd_reg <= cd_sat;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg   <= s_kind;
            value_reg  <= s_value;
            cycles_reg <= s_cycles;
            hdma_reg   <= s_hdma_active;
        end
        if (emit) begin
            m_line            <= lcd_next.line_count;
            m_mode            <= lcd_next.mode;
            m_stat_byte       <= {lcd_next.stat_en, lcd_next.coincidence, lcd_next.mode};
            m_stat_line       <= lcd_next.stat_level;
            m_vblank_line     <= lcd_next.vblank;
            m_stat_irq_rise   <= flags.stat_rise;
            m_vblank_irq_rise <= flags.vblank_rise;
            m_frame_begin     <= flags.frame_begin;
            m_line_render     <= flags.line_render;
            m_hdma_step       <= flags.hdma_step;
            m_last            <= last_c;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> hdl/lmls_checker.sv
// Port-level checks for the LCD mode/line sequencer and their bind to the top level.
`default_nettype none
module lmls_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_line,
    input wire logic [1:0] m_mode,
    input wire logic [6:0] m_stat_byte,
    input wire logic       m_vblank_line,
    input wire logic       m_vblank_irq_rise,
    input wire logic       m_hdma_step,
    input wire logic       m_last
);

    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line) && $stable(m_stat_byte))
        else $error("result beat changed while stalled");

    a_busy_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |-> !s_ready)
        else $error("input taken before the final beat of a tick");

    a_mode_in_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_stat_byte[1:0] == m_mode)
        else $error("STAT mode bits disagree with mode");

    a_vblank_rise_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vblank_irq_rise |-> m_vblank_line && m_mode == lmls_pkg::MODE_VBLANK)
        else $error("VBLANK rise without VBLANK level");

    a_hdma_in_hblank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hdma_step |-> m_mode == lmls_pkg::MODE_HBLANK)
        else $error("HDMA strobe outside hblank");

endmodule

bind lcd_mode_line_sequencer lmls_checker u_lmls_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_line            (m_line),
    .m_mode            (m_mode),
    .m_stat_byte       (m_stat_byte),
    .m_vblank_line     (m_vblank_line),
    .m_vblank_irq_rise (m_vblank_irq_rise),
    .m_hdma_step       (m_hdma_step),
    .m_last            (m_last)
);
`default_nettype wire
